// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/bdlp_pkg.sv -----
package bdlp_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CFG_BITS = 16;
	localparam int CFG_IDX_BITS = 2;
	// Compare width that holds both a counter and a register value.
	localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

	localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = CFG_BITS'(10);
	localparam logic [CFG_BITS-1:0] LONG_PRESS_RESET = CFG_BITS'(1000);

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [CFG_BITS-1:0] cfg_data_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG_PRESS = 2'd1
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BOUNCE_DOWN = 3'd1,
		PH_PRESSED = 3'd2,
		PH_LONG = 3'd3,
		PH_BOUNCE_UP = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_SHORT_DONE = 2'd1,
		EV_LONG_DONE = 2'd2,
		EV_LONG_HELD = 2'd3
	} event_t;

	function automatic count_t sat_inc(input count_t c);
		count_t r;
		r = (c == '1) ? c : c + count_t'(1);
		return r;
	endfunction

endpackage

// ----- rtl/bdlp_tick_if.sv -----
interface bdlp_tick_if;
	logic valid;
	logic ready;
	logic pin_level;

	modport source (output valid, output pin_level, input ready);
	modport sink (input valid, input pin_level, output ready);
endinterface

// ----- rtl/bdlp_event_if.sv -----
interface bdlp_event_if;
	logic valid;
	logic ready;
	logic [1:0] event_code;

	modport source (output valid, output event_code, input ready);
	modport sink (input valid, input event_code, output ready);
endinterface

// ----- rtl/bdlp_cfg_if.sv -----
interface bdlp_cfg_if import bdlp_pkg::*;;
	logic valid;
	logic ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [CFG_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/button_debounce_long_press_unit.sv -----
// Button debouncer with long-press detection.
// Channel tick (sink): one item per time tick, carrying pin_level, the raw
// active-low button pin level. Channel evt (source): one item per tick
// item, carrying event_code (none, short press done, long press done, long
// press still held). Channel cfg (sink): register writes, index 0 is the
// debounce time and index 1 the long-press time, both in ticks; other
// indexes are ignored. Writes are always ready and belong to idle periods.
// Each accepted tick updates the phase and the two saturating counters in
// one pass of logic and loads the event into the output register, so the
// event appears in the cycle after its tick. While the receiver takes each
// event, one tick per cycle is sustained; the single output register sets
// that figure. When the receiver stalls, the event waits in the output
// register and tick ready drops until it is taken; nothing is lost.
// Reset puts the machine in idle with both counters at zero, the registers
// at 10 and 1000 ticks, and the output empty.
module button_debounce_long_press_unit import bdlp_pkg::*; (
	input logic clk,
	input logic arst_n,
	bdlp_tick_if.sink tick,
	bdlp_event_if.source evt,
	bdlp_cfg_if.sink cfg
);

	cfg_data_t debounce_q;
	cfg_data_t long_press_q;
	phase_t phase_q;
	phase_t phase_d;
	count_t change_q;
	count_t change_d;
	count_t press_q;
	count_t press_d;
	logic out_valid_q;
	event_t out_code_q;
	event_t code_d;
	count_t change_inc;
	count_t press_inc;
	logic pressed;
	logic debounced;
	logic long_done;
	logic take;

	assign cfg.ready = 1'b1;
	assign tick.ready = !out_valid_q || evt.ready;
	assign take = tick.valid && tick.ready;
	assign evt.valid = out_valid_q;
	assign evt.event_code = out_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEBOUNCE: debounce_q <= cfg.data;
				REG_LONG_PRESS: long_press_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pressed = !tick.pin_level;
		change_inc = sat_inc(change_q);
		press_inc = sat_inc(press_q);
		debounced = CMP_BITS'(change_inc) >= CMP_BITS'(debounce_q);
		long_done = CMP_BITS'(press_inc) >= CMP_BITS'(long_press_q);
		phase_d = phase_q;
		change_d = change_inc;
		press_d = press_inc;
		code_d = EV_NONE;
		unique case (phase_q)
			PH_IDLE: begin
				if (pressed) begin
					phase_d = PH_BOUNCE_DOWN;
					change_d = '0;
				end
			end
			PH_BOUNCE_DOWN: begin
				if (pressed && debounced) begin
					phase_d = PH_PRESSED;
					press_d = '0;
				end else if (!pressed) begin
					phase_d = PH_IDLE;
					change_d = '0;
				end
			end
			PH_PRESSED: begin
				if (!pressed) begin
					phase_d = PH_BOUNCE_UP;
					change_d = '0;
				end else if (long_done) begin
					phase_d = PH_LONG;
				end
			end
			PH_LONG: begin
				if (!pressed) begin
					phase_d = PH_BOUNCE_UP;
					change_d = '0;
				end else begin
					code_d = EV_LONG_HELD;
				end
			end
			PH_BOUNCE_UP: begin
				if (!pressed && debounced) begin
					phase_d = PH_IDLE;
					code_d = long_done ? EV_LONG_DONE : EV_SHORT_DONE;
				end else if (pressed) begin
					// A press returning during release bouncing resumes the
					// held phase once long_done holds, else the pressed phase.
					phase_d = long_done ? PH_LONG : PH_PRESSED;
					change_d = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			change_q <= '0;
			press_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				change_q <= change_d;
				press_q <= press_d;
				out_valid_q <= 1'b1;
			end else if (evt.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_code_q <= code_d;
		end
	end

endmodule

// ----- rtl/bdlp_checker.sv -----
`include "assert_macros.svh"

module bdlp_checker (
	input logic clk,
	input logic arst_n,
	input logic tick_valid,
	input logic tick_ready,
	input logic evt_valid,
	input logic evt_ready,
	input logic [1:0] evt_event_code
);

	// A stalled event keeps its value.
	`ASSERT_NEXT(a_evt_hold, clk, arst_n, evt_valid && !evt_ready, evt_valid && $stable(evt_event_code))

	// Every accepted tick shows its event in the next cycle.
	`ASSERT_NEXT(a_tick_to_evt, clk, arst_n, tick_valid && tick_ready, evt_valid)

	// A full, stalled output register holds back new ticks.
	`ASSERT_SAME(a_stall_back, clk, arst_n, evt_valid && !evt_ready, !tick_ready)

	// An empty output register never blocks the input.
	`ASSERT_SAME(a_empty_ready, clk, arst_n, !evt_valid, tick_ready)

endmodule

bind button_debounce_long_press_unit bdlp_checker u_bdlp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.tick_valid(tick.valid),
	.tick_ready(tick.ready),
	.evt_valid(evt.valid),
	.evt_ready(evt.ready),
	.evt_event_code(evt.event_code)
);

// ----- test/button_debounce_long_press_unit_tb.sv -----
`timescale 1ns / 100ps

module button_debounce_long_press_unit_tb;
	import bdlp_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int MAX_HOLD_TICKS = 1200;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

	logic clk;
	logic arst_n;

	bdlp_tick_if tick_bus();
	bdlp_event_if event_bus();
	bdlp_cfg_if cfg_bus();

	button_debounce_long_press_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_bus),
		.evt(event_bus),
		.cfg(cfg_bus)
	);

	// Shadow of the debouncer, advanced once per accepted tick item.
	phase_t track_phase = PH_IDLE;
	count_t since_change = '0;
	count_t since_press = '0;
	cfg_data_t debounce_len = DEBOUNCE_RESET;
	cfg_data_t long_len = LONG_PRESS_RESET;

	event_t expected_events[$];
	int mismatches = 0;
	int ticks_sent = 0;
	int cycle_count = 0;
	bit gaps_on = 1'b1;
	bit hold_request = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic event_t debounce_step(input logic level);
		logic pressed;
		logic settled;
		logic held_long;
		event_t code;
		pressed = !level;
		code = EV_NONE;
		// Both counters stick at all ones instead of wrapping.
		if (since_change != '1) since_change = since_change + 1'b1;
		if (since_press != '1) since_press = since_press + 1'b1;
		settled = since_change >= debounce_len;
		held_long = since_press >= long_len;
		case (track_phase)
		PH_IDLE: begin
			if (pressed) begin
				track_phase = PH_BOUNCE_DOWN;
				since_change = '0;
			end
		end
		PH_BOUNCE_DOWN: begin
			if (pressed && settled) begin
				track_phase = PH_PRESSED;
				since_press = '0;
			end else if (!pressed) begin
				track_phase = PH_IDLE;
				since_change = '0;
			end
		end
		PH_PRESSED: begin
			if (!pressed) begin
				track_phase = PH_BOUNCE_UP;
				since_change = '0;
			end else if (held_long) begin
				track_phase = PH_LONG;
			end
		end
		PH_LONG: begin
			if (!pressed) begin
				track_phase = PH_BOUNCE_UP;
				since_change = '0;
			end else begin
				code = EV_LONG_HELD;
			end
		end
		PH_BOUNCE_UP: begin
			if (!pressed && settled) begin
				track_phase = PH_IDLE;
				code = held_long ? EV_LONG_DONE : EV_SHORT_DONE;
			end else if (pressed) begin
				track_phase = held_long ? PH_LONG : PH_PRESSED;
				since_change = '0;
			end
		end
		default: begin
			track_phase = PH_IDLE;
		end
		endcase
		return code;
	endfunction

	always @(posedge clk) begin : scoreboard
		event_t want;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
				REG_DEBOUNCE: debounce_len = cfg_bus.data;
				REG_LONG_PRESS: long_len = cfg_bus.data;
				default: ;
				endcase
			end
			if (tick_bus.valid && tick_bus.ready)
				expected_events.push_back(debounce_step(tick_bus.pin_level));
			if (event_bus.valid && event_bus.ready) begin
				if (expected_events.size() == 0) begin
					$error("event_code item arrived with none expected: got %0d",
						event_bus.event_code);
					mismatches++;
				end else begin
					want = expected_events.pop_front();
					if (event_bus.event_code !== want) begin
						$error("event_code mismatch: expected %0d, got %0d",
							want, event_bus.event_code);
						mismatches++;
					end
				end
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (!gaps_on || roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The event side stalls at random, or for a long stretch on request.
	initial begin
		int stall_left;
		stall_left = 0;
		event_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				event_bus.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_request = 1'b0;
				event_bus.ready <= 1'b1;
			end else if (!gaps_on) begin
				event_bus.ready <= 1'b1;
			end else begin
				if (stall_left > 0)
					stall_left--;
				else if ($urandom_range(0, 99) < 30)
					stall_left = pick_gap();
				event_bus.ready <= (stall_left == 0);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_tick(input logic level);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tick_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_bus.valid <= 1'b1;
		tick_bus.pin_level <= level;
		@(posedge clk);
		while (!tick_bus.ready) @(posedge clk);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic send_pattern(input logic [31:0] bits, input int count);
		for (int i = count - 1; i >= 0; i--) send_tick(bits[i]);
	endtask

	task automatic wait_drained();
		tick_bus.valid <= 1'b0;
		while (expected_events.size() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input cfg_data_t value);
		wait_drained();
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	// One press with bounce on both edges; some are noise or let go too early.
	task automatic press_sequence(input int dbn, input int lng);
		int kind;
		int hold_len;
		kind = $urandom_range(0, 99);
		if (kind < 15) begin
			repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
		end else begin
			repeat ($urandom_range(0, 4)) send_tick(1'b1);
			repeat ($urandom_range(0, 3)) begin
				send_tick(1'b0);
				send_tick(1'b1);
			end
			if (kind < 25)
				hold_len = $urandom_range(0, dbn);
			else if (kind < 60)
				hold_len = dbn + 1 + $urandom_range(0, lng);
			else
				hold_len = dbn + lng + $urandom_range(0, 6);
			if (hold_len > MAX_HOLD_TICKS) hold_len = MAX_HOLD_TICKS;
			repeat (hold_len) send_tick(1'b0);
			repeat ($urandom_range(0, 2)) begin
				send_tick(1'b1);
				send_tick(1'b0);
			end
			repeat (dbn + $urandom_range(0, 3)) send_tick(1'b1);
		end
	endtask

	task automatic test_reset_values();
		// A bounce that aborts, then a short press, under the reset timings.
		send_pattern(32'(25'b1_01_00000000000_11111111111), 25);
	endtask

	task automatic test_directed_events();
		write_reg(REG_DEBOUNCE, 16'd2);
		write_reg(REG_LONG_PRESS, 16'd4);
		// Long press with a bounce back into the held phase, then a second
		// press with a bounce back into the pressed phase; it still ends as long done.
		send_pattern(32'(24'b1_01_000_00000_10_111_000_10_111), 24);
	endtask

	task automatic test_zero_thresholds();
		write_reg(REG_DEBOUNCE, 16'd0);
		write_reg(REG_LONG_PRESS, 16'd0);
		send_pattern(32'(8'b1000_1101), 8);
	endtask

	task automatic test_spare_index();
		// Writes to the unused indexes must leave both timings alone.
		write_reg(REG_SPARE_LO, 16'h0000);
		write_reg(REG_SPARE_HI, 16'hFFFF);
		send_pattern(32'(8'b1000_1101), 8);
	endtask

	task automatic test_max_thresholds();
		write_reg(REG_DEBOUNCE, 16'hFFFF);
		write_reg(REG_LONG_PRESS, 16'hFFFF);
		send_pattern(32'(10'b00001111_01), 10);
	endtask

	task automatic test_random_presses(input int count, input int dbn, input int lng);
		int start;
		write_reg(REG_DEBOUNCE, cfg_data_t'(dbn));
		write_reg(REG_LONG_PRESS, cfg_data_t'(lng));
		start = ticks_sent;
		while (ticks_sent - start < count) press_sequence(dbn, lng);
	endtask

	task automatic test_backpressure();
		int start;
		write_reg(REG_DEBOUNCE, 16'd1);
		write_reg(REG_LONG_PRESS, 16'd5);
		hold_request = 1'b1;
		start = ticks_sent;
		while (ticks_sent - start < 40) press_sequence(1, 5);
		wait (!hold_request);
	endtask

	initial begin
		arst_n = 1'b0;
		tick_bus.valid = 1'b0;
		tick_bus.pin_level = 1'b1;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = REG_DEBOUNCE;
		cfg_bus.data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_directed_events();
		test_zero_thresholds();
		test_spare_index();
		test_max_thresholds();
		test_random_presses(400, 3, 12);
		test_random_presses(300, 10, 1000);
		test_random_presses(300, $urandom_range(0, 6), $urandom_range(0, 60));
		test_random_presses(150, 1, 0);
		test_backpressure();
		gaps_on = 1'b0;
		test_random_presses(200, 5, 40);
		gaps_on = 1'b1;

		wait_drained();
		repeat (5) @(negedge clk);
		if (mismatches == 0 && expected_events.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
